// File: rtl/core/chained_block_allocator_macros.svh
// Assertion macros used by the chained block allocator port checker.
`ifndef CHAINED_BLOCK_ALLOCATOR_MACROS_SVH
`define CHAINED_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define CBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cba_pkg.sv
// Shared types and constants of the chained block allocator.
package cba_pkg;

  localparam int NUM_BLOCKS_DEF = 512;
  localparam int TOTAL_RESET    = 511;
  localparam int MODE_W         = 2;
  localparam int COUNT_W        = 10;
  localparam int BLOCK_W        = 9;
  localparam int STATUS_W       = 2;
  localparam int LINK_W_DEF     = $clog2(NUM_BLOCKS_DEF) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC,
    MODE_FREE,
    MODE_LINK,
    MODE_NOP
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_SPACE,
    ST_BAD_COUNT,
    ST_BAD_START
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHAIN_END,
    S_WALK,
    S_LINK,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [BLOCK_W-1:0]   first_block;
    logic                 chain_end;
    logic [COUNT_W-1:0]   blocks_done;
    logic [COUNT_W-1:0]   free_count;
  } rsp_t;

endpackage

// File: rtl/core/chained_block_allocator.sv
// Chained block allocator top level with the response output register.
// A free map and a chain link table over NUM_BLOCKS disk blocks live in two
// synchronous RAMs with registered reads, and one request is worked at a time.
// How each request is worked:
//   - An allocate scans the free map one block per cycle from block 0,
//     links each free block it takes, then marks the last as chain end.
//   - A free walks its chain one block per cycle and frees each block
//     until it reaches the chain end or stops at a broken link.
//   - A read link or a rejected free checks its start block in both memories.
//   - A rejected allocate or an unused mode goes straight to its response.
// The response register then holds the result until it is taken. The next
// request may be accepted in the cycle the response appears, but its own
// response waits until the register is free. After reset and after every
// write of total_blocks a clearing pass over NUM_BLOCKS blocks marks every
// block free, and requests stall during it. total_blocks writes are taken at
// any time and abandon a request in progress, so they belong between requests.
module chained_block_allocator import cba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [COUNT_W-1:0]  block_count,
  input  logic [BLOCK_W-1:0]  start_block,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [BLOCK_W-1:0]  first_block,
  output logic                chain_end,
  output logic [COUNT_W-1:0]  blocks_done,
  output logic [COUNT_W-1:0]  free_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  total_blocks
);

  logic rsp_free;
  logic rsp_load;
  rsp_t rsp;
  rsp_t rsp_q;

  assign cfg_ready = 1'b1;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  cba_seq #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .block_count (block_count),
    .start_block (start_block),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_total   (total_blocks),
    .rsp_free    (rsp_free),
    .rsp_load    (rsp_load),
    .rsp         (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_q <= rsp;
    end
  end

  assign status      = rsp_q.status;
  assign first_block = rsp_q.first_block;
  assign chain_end   = rsp_q.chain_end;
  assign blocks_done = rsp_q.blocks_done;
  assign free_count  = rsp_q.free_count;

endmodule

// File: rtl/core/cba_ram.sv
// Simple dual-port synchronous RAM with registered read.
module cba_ram import cba_pkg::*; #(
  parameter int DEPTH = NUM_BLOCKS_DEF,
  parameter int WIDTH = LINK_W_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/cba_seq.sv
// Request sequencer with the free map and chain link memories.
module cba_seq import cba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [COUNT_W-1:0] block_count,
  input  logic [BLOCK_W-1:0] start_block,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_total,
  input  logic               rsp_free,
  output logic               rsp_load,
  output rsp_t               rsp
);

  localparam int BW          = $clog2(NUM_BLOCKS);
  localparam int CW          = $clog2(NUM_BLOCKS + 1);
  localparam int XW          = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int CURW        = (BW > BLOCK_W) ? BW : BLOCK_W;
  localparam int LW          = BW + 1;
  localparam int RESET_TOTAL = (TOTAL_RESET > NUM_BLOCKS) ? NUM_BLOCKS : TOTAL_RESET;

  state_t          state, state_next;
  logic [CW-1:0]   total, total_next;
  logic [CW-1:0]   free_cnt, free_next;
  logic [BW-1:0]   clr_addr, clr_next;
  logic [BW-1:0]   scan_addr, scan_next;
  logic [BW-1:0]   chk_addr, chk_next;
  logic            pend, pend_next;
  logic [BW-1:0]   prev, prev_next;
  logic [CURW-1:0] cur, cur_next;
  logic            self_hit, self_next;
  logic [CW-1:0]   done, done_next;
  logic [COUNT_W-1:0] count, count_next;
  rsp_t            res, res_next;

  logic [CW-1:0]   done_inc;
  logic [CW-1:0]   free_inc;
  logic [CW-1:0]   cfg_clamped;
  logic            in_range;
  logic            step_ok;

  logic            map_we;
  logic [BW-1:0]   map_waddr;
  logic            map_wdata;
  logic [BW-1:0]   map_raddr;
  logic            map_rdata;
  logic            link_we;
  logic [BW-1:0]   link_waddr;
  logic [LW-1:0]   link_wdata;
  logic [BW-1:0]   link_raddr;
  logic [LW-1:0]   link_rdata;

  cba_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (1)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  cba_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (LW)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign done_inc    = done + 1'b1;
  assign free_inc    = free_cnt + 1'b1;
  assign cfg_clamped = (XW'(cfg_total) > XW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(cfg_total);
  assign in_range    = XW'(cur) < XW'(total);
  assign step_ok     = in_range && map_rdata && !self_hit;
  assign rsp         = res;

  always_comb begin
    state_next = state;
    total_next = total;
    free_next  = free_cnt;
    clr_next   = clr_addr;
    scan_next  = scan_addr;
    chk_next   = chk_addr;
    pend_next  = pend;
    prev_next  = prev;
    cur_next   = cur;
    self_next  = self_hit;
    done_next  = done;
    count_next = count;
    res_next   = res;
    map_we     = 1'b0;
    map_waddr  = chk_addr;
    map_wdata  = 1'b0;
    map_raddr  = BW'(start_block);
    link_we    = 1'b0;
    link_waddr = prev;
    link_wdata = '0;
    link_raddr = BW'(start_block);
    req_stall  = 1'b1;
    rsp_load   = 1'b0;

    unique case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = 1'b0;
        clr_next  = clr_addr + 1'b1;
        if (clr_addr == BW'(NUM_BLOCKS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          res_next            = '0;
          res_next.free_count = COUNT_W'(free_cnt);
          done_next           = '0;
          count_next          = block_count;
          cur_next            = CURW'(start_block);
          self_next           = 1'b0;
          scan_next           = '0;
          pend_next           = 1'b0;
          unique case (mode_t'(mode))
            MODE_ALLOC: begin
              if (block_count == '0) begin
                res_next.status = ST_BAD_COUNT;
                state_next      = S_DONE;
              end else if (XW'(block_count) >= XW'(free_cnt)) begin
                res_next.status = ST_NO_SPACE;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            MODE_FREE: state_next = S_WALK;
            MODE_LINK: state_next = S_LINK;
            MODE_NOP:  state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        map_raddr = scan_addr;
        scan_next = scan_addr + 1'b1;
        chk_next  = scan_addr;
        pend_next = 1'b1;
        if (pend && !map_rdata) begin
          map_we    = 1'b1;
          map_waddr = chk_addr;
          map_wdata = 1'b1;
          if (done != '0) begin
            link_we    = 1'b1;
            link_waddr = prev;
            link_wdata = {1'b0, chk_addr};
          end else begin
            res_next.first_block = BLOCK_W'(chk_addr);
          end
          prev_next = chk_addr;
          done_next = done_inc;
          if (XW'(done_inc) == XW'(count)) begin
            state_next = S_CHAIN_END;
          end
        end
      end
      S_CHAIN_END: begin
        link_we              = 1'b1;
        link_waddr           = prev;
        link_wdata           = {1'b1, {BW{1'b0}}};
        free_next            = free_cnt - done;
        res_next.blocks_done = COUNT_W'(done);
        res_next.free_count  = COUNT_W'(free_cnt - done);
        state_next           = S_DONE;
      end
      S_WALK: begin
        if (step_ok) begin
          map_we    = 1'b1;
          map_waddr = cur[BW-1:0];
          map_wdata = 1'b0;
          free_next = free_inc;
          done_next = done_inc;
          if (link_rdata[LW-1] || XW'(done_inc) == XW'(NUM_BLOCKS)) begin
            res_next.blocks_done = COUNT_W'(done_inc);
            res_next.free_count  = COUNT_W'(free_inc);
            state_next           = S_DONE;
          end else begin
            cur_next   = CURW'(link_rdata[BW-1:0]);
            self_next  = link_rdata[BW-1:0] == cur[BW-1:0];
            map_raddr  = link_rdata[BW-1:0];
            link_raddr = link_rdata[BW-1:0];
          end
        end else begin
          if (done == '0) begin
            res_next.status = ST_BAD_START;
          end else begin
            res_next.blocks_done = COUNT_W'(done);
            res_next.free_count  = COUNT_W'(free_cnt);
          end
          state_next = S_DONE;
        end
      end
      S_LINK: begin
        if (!(in_range && map_rdata)) begin
          res_next.status = ST_BAD_START;
        end else if (link_rdata[LW-1]) begin
          res_next.chain_end = 1'b1;
        end else begin
          res_next.first_block = BLOCK_W'(link_rdata[BW-1:0]);
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
        clr_next   = '0;
      end
    endcase

    if (cfg_write) begin
      total_next = cfg_clamped;
      free_next  = cfg_clamped;
      clr_next   = '0;
      state_next = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= CW'(RESET_TOTAL);
      free_cnt <= CW'(RESET_TOTAL);
      clr_addr <= '0;
    end else begin
      total    <= total_next;
      free_cnt <= free_next;
      clr_addr <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_next;
    chk_addr  <= chk_next;
    pend      <= pend_next;
    prev      <= prev_next;
    cur       <= cur_next;
    self_hit  <= self_next;
    done      <= done_next;
    count     <= count_next;
    res       <= res_next;
  end

endmodule

// File: rtl/core/cba_checker.sv
// Port-level checker of the chained block allocator and its bind.
`include "chained_block_allocator_macros.svh"

module cba_checker import cba_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic [MODE_W-1:0]   mode,
  input logic [COUNT_W-1:0]  block_count,
  input logic [BLOCK_W-1:0]  start_block,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input logic [STATUS_W-1:0] status,
  input logic [BLOCK_W-1:0]  first_block,
  input logic                chain_end,
  input logic [COUNT_W-1:0]  blocks_done,
  input logic [COUNT_W-1:0]  free_count,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [COUNT_W-1:0]  total_blocks
);

  // A rejected request moves no blocks and reports no link.
  `CBA_ASSERT_NOW(a_error_is_empty, rsp_valid && status != ST_OK, blocks_done == '0 && first_block == '0 && chain_end == 1'b0, "error response carries data")

  // The end of a chain reports no successor and moves no blocks.
  `CBA_ASSERT_NOW(a_end_has_no_next, rsp_valid && chain_end, first_block == '0 && blocks_done == '0 && status == ST_OK, "chain end response inconsistent")

  // Only one request is worked at a time.
  `CBA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request accepted while busy")

  // A stalled response holds its value.
  `CBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(first_block) && $stable(blocks_done) && $stable(free_count), "stalled response changed")

endmodule

bind chained_block_allocator cba_checker u_cba_checker (.*);

// File: tb/sv/chained_block_allocator_checker.sv
// Checker of the chained block allocator: tracks the disk, predicts each response and compares.
module chained_block_allocator_checker import cba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [COUNT_W-1:0]  block_count,
  input  logic [BLOCK_W-1:0]  start_block,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  logic [STATUS_W-1:0] status,
  input  logic [BLOCK_W-1:0]  first_block,
  input  logic                chain_end,
  input  logic [COUNT_W-1:0]  blocks_done,
  input  logic [COUNT_W-1:0]  free_count,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [COUNT_W-1:0]  total_blocks,
  output int                  errors,
  output int                  checked,
  output int                  outstanding
);

  localparam int NBLK = NUM_BLOCKS_DEF;

  int   disk_size;
  int   free_left;
  bit   blk_free [NBLK];
  int   blk_next [NBLK];
  bit   blk_last [NBLK];
  rsp_t pending_rsp [$];
  rsp_t want;

  function automatic void wipe_disk(input int total);
    int b;
    if (total > NBLK) total = NBLK;
    disk_size = total;
    for (b = 0; b < NBLK; b++) begin
      blk_free[b] = (b < total);
      blk_next[b] = 0;
      blk_last[b] = 1'b0;
    end
    free_left = total;
  endfunction

  function automatic rsp_t work_request(input mode_t m, input int cnt, input int st);
    rsp_t r;
    int   b;
    int   prev;
    int   cur;
    int   nxt;
    int   done;
    bit   have_prev;
    bit   walking;
    bit   at_end;
    r = '0;
    r.status = ST_OK;
    done = 0;
    prev = 0;
    have_prev = 1'b0;
    case (m)
      MODE_ALLOC: begin
        if (cnt == 0) begin
          r.status = ST_BAD_COUNT;
        end else if (cnt >= free_left) begin
          r.status = ST_NO_SPACE;
        end else begin
          for (b = 0; b < disk_size && done < cnt; b++) begin
            if (blk_free[b]) begin
              blk_free[b] = 1'b0;
              if (have_prev) begin
                blk_next[prev] = b;
                blk_last[prev] = 1'b0;
              end else begin
                r.first_block = b[BLOCK_W-1:0];
              end
              prev = b;
              have_prev = 1'b1;
              done++;
            end
          end
          if (have_prev) begin
            blk_next[prev] = 0;
            blk_last[prev] = 1'b1;
          end
          free_left -= done;
        end
      end
      MODE_FREE: begin
        if (st >= disk_size || blk_free[st]) begin
          r.status = ST_BAD_START;
        end else begin
          cur = st;
          walking = 1'b1;
          while (walking && done < NBLK) begin
            at_end = blk_last[cur];
            nxt = blk_next[cur];
            blk_free[cur] = 1'b1;
            free_left++;
            done++;
            if (at_end || nxt >= disk_size || blk_free[nxt]) begin
              walking = 1'b0;
            end else begin
              cur = nxt;
            end
          end
        end
      end
      MODE_LINK: begin
        if (st >= disk_size || blk_free[st]) begin
          r.status = ST_BAD_START;
        end else if (blk_last[st]) begin
          r.chain_end = 1'b1;
        end else begin
          r.first_block = blk_next[st][BLOCK_W-1:0];
        end
      end
      default: begin
      end
    endcase
    r.blocks_done = done[COUNT_W-1:0];
    r.free_count = free_left[COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string fname, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: response %0d %s mismatch, expected %0d, actual %0d",
               $time, checked, fname, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      checked = 0;
      wipe_disk(TOTAL_RESET);
      pending_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) wipe_disk(int'(total_blocks));
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t: response with no request waiting, expected none, actual status %0d",
                   $time, status);
        end else begin
          want = pending_rsp.pop_front();
          check_field("status", int'(want.status), int'(status));
          check_field("first_block", int'(want.first_block), int'(first_block));
          check_field("chain_end", int'(want.chain_end), int'(chain_end));
          check_field("blocks_done", int'(want.blocks_done), int'(blocks_done));
          check_field("free_count", int'(want.free_count), int'(free_count));
          checked++;
        end
      end
      if (req_valid && !req_stall) begin
        pending_rsp.push_back(work_request(mode_t'(mode), int'(block_count),
                                           int'(start_block)));
      end
    end
    outstanding <= pending_rsp.size();
  end

endmodule

// File: tb/sv/chained_block_allocator_tb.sv
// Top of the chained block allocator testbench: clock, reset, request stimulus and verdict.
module chained_block_allocator_tb;
  import cba_pkg::*;

  localparam int ITEMS = 1170;
  localparam int LIMIT = 3000000;
  localparam int DRAIN = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [MODE_W-1:0]   mode = MODE_ALLOC;
  logic [COUNT_W-1:0]  block_count = '0;
  logic [BLOCK_W-1:0]  start_block = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [BLOCK_W-1:0]  first_block;
  logic                chain_end;
  logic [COUNT_W-1:0]  blocks_done;
  logic [COUNT_W-1:0]  free_count;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  total_blocks = '0;

  int errors;
  int checked;
  int outstanding;
  int sent;
  int phases;
  int burst_left;
  int stall_style;
  int stall_left;
  int cycles;
  int mode_hits [4];

  chained_block_allocator dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .mode(mode),
    .block_count(block_count),
    .start_block(start_block),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .first_block(first_block),
    .chain_end(chain_end),
    .blocks_done(blocks_done),
    .free_count(free_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .total_blocks(total_blocks)
  );

  chained_block_allocator_checker chk (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .mode(mode),
    .block_count(block_count),
    .start_block(start_block),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .first_block(first_block),
    .chain_end(chain_end),
    .blocks_done(blocks_done),
    .free_count(free_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .total_blocks(total_blocks),
    .errors(errors),
    .checked(checked),
    .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 1) == 1);
      2: rsp_stall <= (stall_left % 3 == 0);
      default: rsp_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task automatic send(input mode_t m, input int cnt, input int st, input bit last);
    req_valid <= 1'b1;
    mode <= m;
    block_count <= cnt[COUNT_W-1:0];
    start_block <= st[BLOCK_W-1:0];
    do @(posedge clk); while (req_stall);
    sent++;
    mode_hits[int'(m)]++;
    if (last || burst_left == 0) begin
      req_valid <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      if (!last) repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle(input int extra);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_total(input int value);
    cfg_valid <= 1'b1;
    total_blocks <= value[COUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  task automatic random_request(input int tsz, input bit last);
    int    pick;
    int    cnt;
    int    st;
    mode_t m;
    pick = $urandom_range(0, 99);
    cnt = $urandom_range(0, 1023);
    if (tsz == 0 || $urandom_range(0, 9) == 0) begin
      st = $urandom_range(0, 511);
    end else begin
      st = $urandom_range(0, tsz - 1);
    end
    if (pick < 40) begin
      m = MODE_ALLOC;
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = $urandom_range(0, 1023);
        2: cnt = $urandom_range(0, tsz + 1);
        default: cnt = $urandom_range(1, (tsz / 4 > 1) ? tsz / 4 : 1);
      endcase
    end else if (pick < 75) begin
      m = MODE_FREE;
    end else if (pick < 95) begin
      m = MODE_LINK;
    end else begin
      m = MODE_NOP;
    end
    send(m, cnt, st, last);
  endtask

  initial begin
    int tot;
    int tsz;
    int n;
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The disk starts at its reset size of 511 blocks.
    send(MODE_ALLOC, 0, 0, 1'b0);
    send(MODE_ALLOC, 511, 0, 1'b0);
    send(MODE_ALLOC, 1023, 511, 1'b0);
    send(MODE_ALLOC, 1, 0, 1'b0);
    send(MODE_ALLOC, 3, 0, 1'b0);
    send(MODE_LINK, 0, 1, 1'b0);
    send(MODE_LINK, 0, 3, 1'b0);
    send(MODE_LINK, 0, 0, 1'b0);
    send(MODE_LINK, 0, 10, 1'b0);
    send(MODE_LINK, 0, 511, 1'b0);
    send(MODE_FREE, 0, 0, 1'b0);
    send(MODE_FREE, 0, 0, 1'b0);
    send(MODE_FREE, 0, 2, 1'b0);
    send(MODE_FREE, 0, 1, 1'b0);
    send(MODE_NOP, 1023, 511, 1'b0);
    send(MODE_ALLOC, 510, 0, 1'b0);
    send(MODE_ALLOC, 1, 0, 1'b0);
    send(MODE_LINK, 0, 509, 1'b0);
    send(MODE_FREE, 0, 511, 1'b0);
    send(MODE_FREE, 0, 0, 1'b0);
    send(MODE_LINK, 0, 5, 1'b1);
    wait_idle(8);

    while (sent < ITEMS) begin
      case (phases)
        0: tot = 512;
        1: tot = 0;
        2: tot = 1023;
        3: tot = 1;
        4: tot = 2;
        5: tot = 3;
        default: tot = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 512)
                                                   : $urandom_range(4, 64);
      endcase
      set_total(tot);
      tsz = (tot > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : tot;
      n = (tsz <= 1) ? 20 : $urandom_range(60, 120);
      if (n > ITEMS - sent) n = ITEMS - sent;
      for (i = 0; i < n; i++) random_request(tsz, i == n - 1);
      wait_idle(8);
    end
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d requests over %0d disk sizes: %0d allocate, %0d free, %0d read link, %0d unused.",
             sent, phases + 1, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    $display("Checked %0d responses against the predicted free map and chain table.", checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
